// ===== rtl/mps_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the streaming 2-D max pooling block.
package mps_pkg;

	// Configuration port geometry
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 9;
	localparam int CFG_DIM_BITS    = 9;
	localparam int CFG_POOL_BITS   = 3;
	localparam int CFG_STRIDE_BITS = 4;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POOL_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_POOL_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE_STEP  = 3'd4;

	// Register reset values
	localparam logic [CFG_DIM_BITS-1:0]    RST_INPUT_WIDTH  = 9'd256;
	localparam logic [CFG_DIM_BITS-1:0]    RST_INPUT_HEIGHT = 9'd256;
	localparam logic [CFG_POOL_BITS-1:0]   RST_POOL_WIDTH   = 3'd2;
	localparam logic [CFG_POOL_BITS-1:0]   RST_POOL_HEIGHT  = 3'd2;
	localparam logic [CFG_STRIDE_BITS-1:0] RST_STRIDE_STEP  = 4'd2;

	// Default sizes
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_POOL   = 4;
	localparam int DEF_DATA_BITS  = 16;

	// Stride limit and phase counter width
	localparam int MAX_STRIDE = 8;
	localparam int PHASE_BITS = 3;

	// Result width and queue depths
	localparam int POOLED_BITS  = 15;
	localparam int MID_DEPTH    = 4;
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic [POOLED_BITS-1:0] value;
		logic                   last;
	} result_t;

endpackage

// ===== rtl/max_pooling_2d_stream.sv =====
`timescale 1ns / 1ps
// Top level of the streaming 2-D max pooling block.
//
//  channel   direction  handshake                 payload
//  input     in         push / full               sample
//  result    out        pop / empty               pooled_value, last_in_frame
//  config    in         wr_en (no back-pressure)  wr_index, wr_data
//
// One sample per cycle sustained while full is low; a result passes the mid queue, the line
// store read, the column maximum register and the output queue before the result ports.
// The line store is one bank per window row, each written or read once a cycle.
// Reset clears control state only; there is no clearing pass over the line store.
// A stalled result side fills the output queue, then the mid queue, then raises full.
// A register write restarts the frame counters; the line store keeps its contents.
module max_pooling_2d_stream #(
	parameter int MAX_WIDTH  = mps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mps_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_POOL   = mps_pkg::DEF_MAX_POOL,
	parameter int DATA_BITS  = mps_pkg::DEF_DATA_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [mps_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]  wr_data,
	input  logic                               push,
	output logic                               full,
	input  logic signed [DATA_BITS-1:0]        sample,
	output logic                               empty,
	input  logic                               pop,
	output logic [mps_pkg::POOLED_BITS-1:0]    pooled_value,
	output logic                               last_in_frame
);

	import mps_pkg::*;

	localparam int XB     = $clog2(MAX_WIDTH);
	localparam int BB     = $clog2(MAX_POOL);
	localparam int ITEM_W = DATA_BITS + XB + BB + 2 * MAX_POOL + 2;

	logic              item_push;
	logic [ITEM_W-1:0] item_in;
	logic              item_pop;
	logic [ITEM_W-1:0] item_out;
	logic              item_empty;
	logic                    res_push;
	result_t                 res_in;
	result_t                 res_out;
	logic [OUT_CNT_BITS-1:0] out_count;

	// Accept and tag samples
	mps_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_POOL  (MAX_POOL),
		.DATA_BITS (DATA_BITS),
		.ITEM_W    (ITEM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.push     (push),
		.q_full   (full),
		.sample   (sample),
		.item_push(item_push),
		.item_data(item_in)
	);

	// Decouple front and back
	mps_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (item_push),
		.din   (item_in),
		.full  (full),
		.pop   (item_pop),
		.dout  (item_out),
		.empty (item_empty),
		.count ()
	);

	// Line store and pooling
	mps_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_POOL (MAX_POOL),
		.DATA_BITS(DATA_BITS),
		.ITEM_W   (ITEM_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_empty(item_empty),
		.item_pop  (item_pop),
		.item_data (item_out),
		.out_count (out_count),
		.res_push  (res_push),
		.res_data  (res_in)
	);

	// Output queue
	mps_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (),
		.pop   (pop),
		.dout  (res_out),
		.empty (empty),
		.count (out_count)
	);

	assign pooled_value  = res_out.value;
	assign last_in_frame = res_out.last;

endmodule

// ===== rtl/mps_fifo.sv =====
`timescale 1ns / 1ps
// Small register-based FIFO used between the pooling stages and at the output.
module mps_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PB = $clog2(DEPTH);
	localparam int CB = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PB-1:0]    wr_ptr_q;
	logic [PB-1:0]    rd_ptr_q;
	logic [CB-1:0]    count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign full    = (count_q == CB'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign dout    = mem_q[rd_ptr_q];
	assign wr_fire = push && !full;
	assign rd_fire = pop && !empty;

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PB'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PB'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_fire && !rd_fire) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fifo occupancy did not grow on a lone write");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("fifo pointers differ while empty");

endmodule

// ===== rtl/mps_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, position and phase counters, item tagging.
module mps_front #(
	parameter int MAX_WIDTH  = mps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mps_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_POOL   = mps_pkg::DEF_MAX_POOL,
	parameter int DATA_BITS  = mps_pkg::DEF_DATA_BITS,
	parameter int ITEM_W     = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [mps_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [mps_pkg::CFG_DATA_BITS-1:0]  wr_data,
	input  logic                               push,
	input  logic                               q_full,
	input  logic signed [DATA_BITS-1:0]        sample,
	output logic                               item_push,
	output logic [ITEM_W-1:0]                  item_data
);

	import mps_pkg::*;

	localparam int XB = $clog2(MAX_WIDTH);
	localparam int YB = $clog2(MAX_HEIGHT);
	localparam int BB = $clog2(MAX_POOL);
	localparam int WB = XB + 1;
	localparam int HB = YB + 1;
	localparam int PB = $clog2(MAX_POOL + 1);

	typedef struct packed {
		logic [DATA_BITS-1:0] sample;
		logic [XB-1:0]        col;
		logic [BB-1:0]        bank;
		logic [MAX_POOL-1:0]  rd_mask;
		logic [MAX_POOL-1:0]  pool_mask;
		logic                 emit;
		logic                 last;
	} item_t;

	logic [CFG_DIM_BITS-1:0]    width_q;
	logic [CFG_DIM_BITS-1:0]    height_q;
	logic [CFG_POOL_BITS-1:0]   pool_w_q;
	logic [CFG_POOL_BITS-1:0]   pool_h_q;
	logic [CFG_STRIDE_BITS-1:0] stride_q;

	logic [XB-1:0]         col_q;
	logic [YB-1:0]         row_q;
	logic [BB-1:0]         bank_q;
	logic [PHASE_BITS-1:0] col_phase_q;
	logic [PHASE_BITS-1:0] row_phase_q;

	logic [WB-1:0]              w_eff;
	logic [HB-1:0]              h_eff;
	logic [PB-1:0]              pw_eff;
	logic [PB-1:0]              ph_eff;
	logic [CFG_STRIDE_BITS-1:0] st_eff;
	logic [PHASE_BITS-1:0]      col_phase_n;
	logic [PHASE_BITS-1:0]      row_phase_n;
	logic                       accept;
	item_t                      item;

	assign accept    = push && !q_full;
	assign item_push = accept;
	assign item_data = item;

	// Clamp the registers into their legal ranges
	always_comb begin
		if (width_q == '0) begin
			w_eff = WB'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HB'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HB'(MAX_HEIGHT);
		end else begin
			h_eff = HB'(height_q);
		end
		if (pool_w_q == '0) begin
			pw_eff = PB'(1);
		end else if (32'(pool_w_q) > 32'(MAX_POOL)) begin
			pw_eff = PB'(MAX_POOL);
		end else begin
			pw_eff = PB'(pool_w_q);
		end
		if (pool_h_q == '0) begin
			ph_eff = PB'(1);
		end else if (32'(pool_h_q) > 32'(MAX_POOL)) begin
			ph_eff = PB'(MAX_POOL);
		end else begin
			ph_eff = PB'(pool_h_q);
		end
		if (stride_q == '0) begin
			st_eff = CFG_STRIDE_BITS'(1);
		end else if (32'(stride_q) > 32'(MAX_STRIDE)) begin
			st_eff = CFG_STRIDE_BITS'(MAX_STRIDE);
		end else begin
			st_eff = stride_q;
		end
	end

	// Work out the phases after this sample
	always_comb begin
		if (32'(col_q) + 32'd1 == 32'(pw_eff)) begin
			col_phase_n = '0;
		end else if (32'(col_q) >= 32'(pw_eff)) begin
			col_phase_n = (32'(col_phase_q) + 32'd1 >= 32'(st_eff)) ? '0
				: col_phase_q + 1'b1;
		end else begin
			col_phase_n = col_phase_q;
		end
		row_phase_n = row_phase_q;
		if (col_q == '0) begin
			if (32'(row_q) + 32'd1 == 32'(ph_eff)) begin
				row_phase_n = '0;
			end else if (32'(row_q) >= 32'(ph_eff)) begin
				row_phase_n = (32'(row_phase_q) + 32'd1 >= 32'(st_eff)) ? '0
					: row_phase_q + 1'b1;
			end
		end
	end

	// Tag the item for the back end
	always_comb begin
		int row_gap;
		row_gap = 0;
		item.sample = sample;
		item.col    = col_q;
		item.bank   = bank_q;
		for (int b = 0; b < MAX_POOL; b++) begin
			row_gap = (32'(bank_q) >= b) ? 32'(bank_q) - b : 32'(bank_q) + MAX_POOL - b;
			item.rd_mask[b] = (row_gap >= 1) && (row_gap < 32'(ph_eff))
				&& (32'(row_q) >= row_gap);
			item.pool_mask[b] = (b < 32'(pw_eff));
		end
		item.emit = (32'(col_q) + 32'd1 >= 32'(pw_eff)) && (32'(row_q) + 32'd1 >= 32'(ph_eff))
			&& (col_phase_n == '0) && (row_phase_n == '0);
		item.last = (32'(col_q) + 32'(st_eff) >= 32'(w_eff))
			&& (32'(row_q) + 32'(st_eff) >= 32'(h_eff));
	end

	// Write registers, restart the frame, advance the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= RST_INPUT_WIDTH;
			height_q    <= RST_INPUT_HEIGHT;
			pool_w_q    <= RST_POOL_WIDTH;
			pool_h_q    <= RST_POOL_HEIGHT;
			stride_q    <= RST_STRIDE_STEP;
			col_q       <= '0;
			row_q       <= '0;
			bank_q      <= '0;
			col_phase_q <= '0;
			row_phase_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INPUT_WIDTH: begin
					width_q <= wr_data;
				end
				REG_INPUT_HEIGHT: begin
					height_q <= wr_data;
				end
				REG_POOL_WIDTH: begin
					pool_w_q <= wr_data[CFG_POOL_BITS-1:0];
				end
				REG_POOL_HEIGHT: begin
					pool_h_q <= wr_data[CFG_POOL_BITS-1:0];
				end
				REG_STRIDE_STEP: begin
					stride_q <= wr_data[CFG_STRIDE_BITS-1:0];
				end
				default: begin
				end
			endcase
			if (wr_index == REG_INPUT_WIDTH || wr_index == REG_INPUT_HEIGHT
				|| wr_index == REG_POOL_WIDTH || wr_index == REG_POOL_HEIGHT
				|| wr_index == REG_STRIDE_STEP) begin
				col_q       <= '0;
				row_q       <= '0;
				bank_q      <= '0;
				col_phase_q <= '0;
				row_phase_q <= '0;
			end
		end else if (accept) begin
			col_phase_q <= col_phase_n;
			row_phase_q <= row_phase_n;
			if (32'(col_q) + 32'd1 >= 32'(w_eff)) begin
				col_q <= '0;
				if (32'(row_q) + 32'd1 >= 32'(h_eff)) begin
					row_q  <= '0;
					bank_q <= '0;
				end else begin
					row_q  <= row_q + 1'b1;
					bank_q <= (bank_q == BB'(MAX_POOL - 1)) ? '0 : bank_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (32'(col_q) < 32'(w_eff)))
		else $error("column counter outside the frame on an accepted sample");

endmodule

// ===== rtl/mps_back.sv =====
`timescale 1ns / 1ps
// Back end: banked line store, column maxima, window maximum and result issue.
module mps_back #(
	parameter int MAX_WIDTH = mps_pkg::DEF_MAX_WIDTH,
	parameter int MAX_POOL  = mps_pkg::DEF_MAX_POOL,
	parameter int DATA_BITS = mps_pkg::DEF_DATA_BITS,
	parameter int ITEM_W    = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_empty,
	output logic                              item_pop,
	input  logic [ITEM_W-1:0]                 item_data,
	input  logic [mps_pkg::OUT_CNT_BITS-1:0]  out_count,
	output logic                              res_push,
	output mps_pkg::result_t                  res_data
);

	import mps_pkg::*;

	localparam int XB = $clog2(MAX_WIDTH);
	localparam int BB = $clog2(MAX_POOL);

	typedef struct packed {
		logic [DATA_BITS-1:0] sample;
		logic [XB-1:0]        col;
		logic [BB-1:0]        bank;
		logic [MAX_POOL-1:0]  rd_mask;
		logic [MAX_POOL-1:0]  pool_mask;
		logic                 emit;
		logic                 last;
	} item_t;

	typedef struct packed {
		logic [MAX_POOL-1:0] pool_mask;
		logic                emit;
		logic                last;
	} issue_t;

	item_t                       itm;
	logic [DATA_BITS-1:0]        line_mem [MAX_POOL][MAX_WIDTH];
	logic [DATA_BITS-1:0]        rd_s1 [MAX_POOL];
	logic                        v_s1;
	item_t                       item_s1;
	logic                        v_s2;
	issue_t                      issue_s2;
	logic signed [DATA_BITS-1:0] shift_q [MAX_POOL];
	logic signed [DATA_BITS-1:0] col_max;
	logic signed [DATA_BITS-1:0] win_max;
	logic [OUT_CNT_BITS:0]       in_flight;

	assign itm = item_data;

	// Pop only with room left in the output queue for everything in flight
	assign in_flight = {1'b0, out_count} + (OUT_CNT_BITS + 1)'(v_s1)
		+ (OUT_CNT_BITS + 1)'(v_s2);
	assign item_pop = !item_empty && (in_flight < (OUT_CNT_BITS + 1)'(OUT_DEPTH));

	// Write the current row bank, read the other banks at the same column
	always_ff @(posedge clk) begin
		if (item_pop) begin
			for (int b = 0; b < MAX_POOL; b++) begin
				if (itm.bank == BB'(b)) begin
					line_mem[b][itm.col] <= itm.sample;
				end else begin
					rd_s1[b] <= line_mem[b][itm.col];
				end
			end
		end
	end

	// Hold the popped item alongside its read data
	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_s1 <= itm;
		end
		if (v_s1) begin
			issue_s2.pool_mask <= item_s1.pool_mask;
			issue_s2.emit      <= item_s1.emit;
			issue_s2.last      <= item_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= item_pop;
			v_s2 <= v_s1;
		end
	end

	// Column maximum over the rows of the window
	always_comb begin
		col_max = $signed(item_s1.sample);
		for (int b = 0; b < MAX_POOL; b++) begin
			if (item_s1.rd_mask[b] && ($signed(rd_s1[b]) > col_max)) begin
				col_max = $signed(rd_s1[b]);
			end
		end
	end

	// Shift in the new column maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_POOL; i++) begin
				shift_q[i] <= '0;
			end
		end else if (v_s1) begin
			shift_q[0] <= col_max;
			for (int i = 1; i < MAX_POOL; i++) begin
				shift_q[i] <= shift_q[i-1];
			end
		end
	end

	// Window maximum, floored at zero
	always_comb begin
		win_max = '0;
		for (int i = 0; i < MAX_POOL; i++) begin
			if (issue_s2.pool_mask[i] && (shift_q[i] > win_max)) begin
				win_max = shift_q[i];
			end
		end
	end

	assign res_push       = v_s2 && issue_s2.emit;
	assign res_data.value = POOLED_BITS'(win_max);
	assign res_data.last  = issue_s2.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (out_count < OUT_CNT_BITS'(OUT_DEPTH)))
		else $error("result issued into a full output queue");
	a_stage_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(item_pop, 2))
		else $error("second stage valid without a pop two cycles earlier");

endmodule

// ===== verif/tb_max_pooling_2d_stream.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the streaming 2-D max pooling block.
module tb_max_pooling_2d_stream;
	import mps_pkg::*;

	localparam int MAX_W          = DEF_MAX_WIDTH;
	localparam int MAX_H          = DEF_MAX_HEIGHT;
	localparam int POOL_MAX       = DEF_MAX_POOL;
	localparam int SAMPLE_BITS    = DEF_DATA_BITS;
	localparam int NUM_REGS       = 5;
	localparam int RESET_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 12;
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 1500;

	typedef enum logic [1:0] {ACT_SAMPLE, ACT_CONFIG, ACT_DRAIN} action_t;

	typedef struct {
		action_t                        kind;
		logic signed [SAMPLE_BITS-1:0]  value;
		logic [CFG_IDX_BITS-1:0]        idx;
		logic [CFG_DATA_BITS-1:0]       data;
	} feed_item_t;

	// DUT ports
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]         wr_index = '0;
	logic [CFG_DATA_BITS-1:0]        wr_data = '0;
	logic                            push = 1'b0;
	logic                            full;
	logic signed [SAMPLE_BITS-1:0]   sample = '0;
	logic                            empty;
	logic                            pop = 1'b0;
	logic [POOLED_BITS-1:0]          pooled_value;
	logic                            last_in_frame;

	// Stimulus and scoreboard
	feed_item_t feed_q[$];
	result_t    pooled_due[$];
	int         sample_total = 0;
	int         plan_w = int'(RST_INPUT_WIDTH);
	int         plan_h = int'(RST_INPUT_HEIGHT);
	int         fail_count = 0;
	bit         timed_out = 1'b0;

	// Handshake and pacing bookkeeping of the driver, monitor and watchdog
	bit push_taken = 1'b0;
	bit pop_taken = 1'b0;
	bit calm = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int settle_cnt = 0;
	int quiet_cycles = 0;

	// Pooling model state
	int                            reg_width  = int'(RST_INPUT_WIDTH);
	int                            reg_height = int'(RST_INPUT_HEIGHT);
	int                            reg_pool_w = int'(RST_POOL_WIDTH);
	int                            reg_pool_h = int'(RST_POOL_HEIGHT);
	int                            reg_stride = int'(RST_STRIDE_STEP);
	logic signed [SAMPLE_BITS-1:0] line_mem [POOL_MAX*MAX_W];
	logic signed [SAMPLE_BITS-1:0] col_peaks [POOL_MAX];
	int                            col_cnt = 0;
	int                            row_cnt = 0;
	int                            col_phase = 0;
	int                            row_phase = 0;

	max_pooling_2d_stream dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.push          (push),
		.full          (full),
		.sample        (sample),
		.empty         (empty),
		.pop           (pop),
		.pooled_value  (pooled_value),
		.last_in_frame (last_in_frame)
	);

	always #4 clk = ~clk;

	// Saturate a register value into 1..hi
	function automatic int eff_value(input int v, input int hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Apply a register write and restart the frame
	task automatic pool_set_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] d);
		case (idx)
		REG_INPUT_WIDTH:  reg_width  = int'(d);
		REG_INPUT_HEIGHT: reg_height = int'(d);
		REG_POOL_WIDTH:   reg_pool_w = int'(d[CFG_POOL_BITS-1:0]);
		REG_POOL_HEIGHT:  reg_pool_h = int'(d[CFG_POOL_BITS-1:0]);
		REG_STRIDE_STEP:  reg_stride = int'(d[CFG_STRIDE_BITS-1:0]);
		default: return;
		endcase
		col_cnt = 0;
		row_cnt = 0;
		col_phase = 0;
		row_phase = 0;
		foreach (col_peaks[i]) col_peaks[i] = '0;
	endtask

	// Advance the pooling model by one sample and queue any window maximum
	task automatic pool_step(input logic signed [SAMPLE_BITS-1:0] s);
		int w, h, pw, ph, st, x, y, r, i;
		logic signed [SAMPLE_BITS-1:0] col_peak, v, peak;
		result_t res;
		w  = eff_value(reg_width, MAX_W);
		h  = eff_value(reg_height, MAX_H);
		pw = eff_value(reg_pool_w, POOL_MAX);
		ph = eff_value(reg_pool_h, POOL_MAX);
		st = eff_value(reg_stride, MAX_STRIDE);
		x = col_cnt;
		y = row_cnt;
		if (x >= w) x = 0;
		if (y >= h) y = 0;
		line_mem[(y % POOL_MAX) * MAX_W + x] = s;
		// fold the rows above into this column's maximum
		col_peak = s;
		for (r = 1; r < ph; r++) begin
			if (y >= r) begin
				v = line_mem[((y - r) % POOL_MAX) * MAX_W + x];
				if (v > col_peak) col_peak = v;
			end
		end
		for (i = POOL_MAX - 1; i > 0; i--) col_peaks[i] = col_peaks[i - 1];
		col_peaks[0] = col_peak;
		// track distance from the last window origin
		if (x + 1 == pw) col_phase = 0;
		else if (x >= pw) col_phase = (col_phase + 1 >= st) ? 0 : col_phase + 1;
		if (x == 0) begin
			if (y + 1 == ph) row_phase = 0;
			else if (y >= ph) row_phase = (row_phase + 1 >= st) ? 0 : row_phase + 1;
		end
		// close a window at its bottom-right sample
		if (x + 1 >= pw && y + 1 >= ph && col_phase == 0 && row_phase == 0) begin
			peak = '0;
			for (i = 0; i < pw; i++)
				if (col_peaks[i] > peak) peak = col_peaks[i];
			res.value = peak[POOLED_BITS-1:0];
			res.last = (x + st >= w && y + st >= h);
			pooled_due.push_back(res);
		end
		if (x + 1 >= w) begin
			x = 0;
			y = (y + 1 >= h) ? 0 : y + 1;
		end else begin
			x++;
		end
		col_cnt = x;
		row_cnt = y;
	endtask

	task automatic stage_sample(input logic signed [SAMPLE_BITS-1:0] v);
		feed_item_t it;
		it.kind = ACT_SAMPLE;
		it.value = v;
		it.idx = '0;
		it.data = '0;
		feed_q.push_back(it);
		sample_total++;
	endtask

	task automatic stage_write(input logic [CFG_IDX_BITS-1:0] idx, input int d);
		feed_item_t it;
		it.kind = ACT_CONFIG;
		it.value = '0;
		it.idx = idx;
		it.data = d[CFG_DATA_BITS-1:0];
		feed_q.push_back(it);
		if (idx == REG_INPUT_WIDTH) plan_w = int'(d[CFG_DIM_BITS-1:0]);
		if (idx == REG_INPUT_HEIGHT) plan_h = int'(d[CFG_DIM_BITS-1:0]);
	endtask

	// Hold the sender until every pending result has come out
	task automatic stage_drain();
		feed_item_t it;
		it.kind = ACT_DRAIN;
		it.value = '0;
		it.idx = '0;
		it.data = '0;
		feed_q.push_back(it);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
		0: return 16'sh8000;
		1: return 16'sh7FFF;
		2: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
		3, 4: return SAMPLE_BITS'(-$urandom_range(1, 32767));
		default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic int pick_dim();
		return ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
	endfunction

	// Pool size in the low bits, noise above to check the masking
	function automatic int pick_pool();
		int p;
		p = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
		return ($urandom_range(0, 63) << CFG_POOL_BITS) | p;
	endfunction

	function automatic int pick_stride();
		int s;
		s = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
		return ($urandom_range(0, 31) << CFG_STRIDE_BITS) | s;
	endfunction

	// Mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Driver: change inputs on the falling edge
	always @(negedge clk) begin
		feed_item_t head;
		logic nx_push, nx_pop, nx_wr;
		logic signed [SAMPLE_BITS-1:0] nx_sample;
		logic [CFG_IDX_BITS-1:0] nx_idx;
		logic [CFG_DATA_BITS-1:0] nx_data;
		nx_push = push;
		nx_pop = pop;
		nx_wr = 1'b0;
		nx_sample = sample;
		nx_idx = wr_index;
		nx_data = wr_data;
		if (arst_n) begin
			if ($urandom_range(0, 299) == 0) calm = !calm;
			// count idle cycles ahead of a register write
			if (push || pooled_due.size() != 0) settle_cnt = 0;
			else if (settle_cnt < SETTLE_CYCLES) settle_cnt++;
			// input side: hold an offered sample until its transaction
			if (!push || push_taken) begin
				nx_push = 1'b0;
				if (push_taken) send_gap = pick_gap();
				if (send_gap > 0) begin
					send_gap--;
				end else if (feed_q.size() != 0) begin
					head = feed_q[0];
					if (head.kind == ACT_SAMPLE) begin
						void'(feed_q.pop_front());
						nx_push = 1'b1;
						nx_sample = head.value;
					end else if (pooled_due.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
						void'(feed_q.pop_front());
						if (head.kind == ACT_CONFIG) begin
							nx_wr = 1'b1;
							nx_idx = head.idx;
							nx_data = head.data;
						end
					end
				end
			end
			// result side: stall at random after each transaction
			if (pop_taken) stall_left = pick_gap();
			if (stall_left > 0) begin
				nx_pop = 1'b0;
				stall_left--;
			end else begin
				nx_pop = 1'b1;
			end
		end
		push <= nx_push;
		pop <= nx_pop;
		wr_en <= nx_wr;
		sample <= nx_sample;
		wr_index <= nx_idx;
		wr_data <= nx_data;
	end

	// Monitor: sample both channels and the write port on the rising edge
	always @(posedge clk) begin
		result_t want;
		push_taken = 1'b0;
		pop_taken = 1'b0;
		if (arst_n) begin
			if (pop && !empty) begin
				pop_taken = 1'b1;
				if (pooled_due.size() == 0) begin
					$error("unexpected result: pooled_value %0d, last_in_frame %0b",
						pooled_value, last_in_frame);
					fail_count++;
				end else begin
					want = pooled_due.pop_front();
					if (pooled_value !== want.value) begin
						$error("pooled_value: expected %0d, got %0d", want.value, pooled_value);
						fail_count++;
					end
					if (last_in_frame !== want.last) begin
						$error("last_in_frame: expected %0b, got %0b", want.last, last_in_frame);
						fail_count++;
					end
				end
			end
			if (wr_en) pool_set_reg(wr_index, wr_data);
			if (push && !full) begin
				push_taken = 1'b1;
				pool_step(sample);
			end
		end
	end

	// Watchdog: stop when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || wr_en) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				timed_out = 1'b1;
			end
		end
	end

	initial begin
		logic signed [SAMPLE_BITS-1:0] corner [16];
		int phase, f, k, frames, cut, len, wrote;

		// 4x4 frame, 2x2 windows at stride 2: extremes and all-negative windows
		stage_write(REG_INPUT_WIDTH, 4);
		stage_write(REG_INPUT_HEIGHT, 4);
		stage_write(REG_POOL_WIDTH, 2);
		stage_write(REG_POOL_HEIGHT, 2);
		stage_write(REG_STRIDE_STEP, 2);
		stage_write(NUM_REGS, 9'h1FF);
		corner = '{16'sh8000, -16'sd1, 16'sh7FFF, 16'sd0,
			-16'sd256, -16'sd32767, 16'sd1, 16'sd256,
			-16'sd128, -16'sd21846, 16'sd21845, 16'sd255,
			-16'sd3, -16'sd2, 16'sd16384, 16'sd4660};
		for (k = 0; k < 16; k++) begin
			stage_sample(corner[k]);
			if (k == 7) stage_drain();
		end
		// window wider than the frame: nothing comes out
		stage_write(REG_INPUT_WIDTH, 3);
		stage_write(REG_INPUT_HEIGHT, 3);
		stage_write(REG_POOL_WIDTH, 4);
		for (k = 0; k < 9; k++) stage_sample(rand_sample());

		// random phases of whole frames, a few cut short
		for (phase = 0; sample_total < ITEM_TARGET; phase++) begin
			case (phase)
			2: begin
				stage_write(REG_INPUT_WIDTH, $urandom_range(256, 511));
				stage_write(REG_INPUT_HEIGHT, 2);
				stage_write(REG_POOL_WIDTH, 4);
				stage_write(REG_POOL_HEIGHT, 2);
				stage_write(REG_STRIDE_STEP, 1);
			end
			5: begin
				stage_write(REG_INPUT_WIDTH, 1);
				stage_write(REG_INPUT_HEIGHT, $urandom_range(256, 511));
				stage_write(REG_POOL_WIDTH, 0);
				stage_write(REG_POOL_HEIGHT, 4);
				stage_write(REG_STRIDE_STEP, $urandom_range(8, 15));
			end
			8: begin
				stage_write(REG_INPUT_WIDTH, 1);
				stage_write(REG_INPUT_HEIGHT, 1);
				stage_write(REG_POOL_WIDTH, 1);
				stage_write(REG_POOL_HEIGHT, 1);
				stage_write(REG_STRIDE_STEP, 0);
			end
			default: begin
				wrote = 0;
				if (phase == 0 || $urandom_range(0, 1)) begin
					stage_write(REG_INPUT_WIDTH, pick_dim());
					wrote++;
				end
				if (phase == 0 || $urandom_range(0, 1)) begin
					stage_write(REG_INPUT_HEIGHT, pick_dim());
					wrote++;
				end
				if (phase == 0 || $urandom_range(0, 1)) begin
					stage_write(REG_POOL_WIDTH, pick_pool());
					wrote++;
				end
				if (phase == 0 || $urandom_range(0, 1)) begin
					stage_write(REG_POOL_HEIGHT, pick_pool());
					wrote++;
				end
				if (phase == 0 || $urandom_range(0, 3) == 0)
					stage_write($urandom_range(NUM_REGS, (1 << CFG_IDX_BITS) - 1),
						$urandom_range(0, 511));
				if (phase == 0 || wrote == 0 || $urandom_range(0, 1))
					stage_write(REG_STRIDE_STEP, pick_stride());
			end
			endcase
			len = eff_value(plan_w, MAX_W) * eff_value(plan_h, MAX_H);
			frames = (len > 200) ? 1 : (len < 8) ? $urandom_range(3, 8) : $urandom_range(1, 3);
			for (f = 0; f < frames; f++) begin
				cut = len;
				if (f == frames - 1 && len > 1 && $urandom_range(0, 4) == 0)
					cut = $urandom_range(1, len - 1);
				for (k = 0; k < cut; k++) begin
					stage_sample(rand_sample());
					if ($urandom_range(0, 299) == 0) stage_drain();
				end
			end
		end
		stage_drain();

		// release reset, then run until everything has come out
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		while (!timed_out && (feed_q.size() != 0 || push || wr_en || pooled_due.size() != 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (!timed_out && fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mps_pkg.sv
rtl/mps_fifo.sv
rtl/mps_front.sv
rtl/mps_back.sv
rtl/max_pooling_2d_stream.sv
verif/tb_max_pooling_2d_stream.sv
